// ===== hdl/bfm_pkg.sv =====
// Shared types, constants and command codes for the Bloom filter key unit.
// Depends on nothing; the top level, datapath, controller and test use it.
`timescale 1ns / 1ps

package bfm_pkg;

    // request kinds
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_NUM_HASHES = 2'd0;
    localparam logic [1:0] CFG_NUM_BITS   = 2'd1;

    localparam logic [4:0]  NUM_HASHES_RESET = 5'd4;
    localparam logic [16:0] NUM_BITS_RESET   = 17'd65536;

    // hash constants
    localparam logic [31:0] MUR_C1   = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2   = 32'h1b873593;
    localparam logic [31:0] MUR_ADD  = 32'he6546b64;
    localparam logic [31:0] FMIX_C1  = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2  = 32'hc2b2ae35;
    localparam logic [31:0] SEED_STEP = 32'd10;

    localparam int NUM_DIGITS = 20;
    localparam int WORD_BITS  = 32;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] range_value;
    } request_t;

    typedef struct packed {
        logic       is_member;
        logic [1:0] done_type;
    } result_t;

    // datapath commands
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLR_STEP,
        DP_BCD_STEP,
        DP_NORM_STEP,
        DP_HASH_INIT,
        DP_BLK_MUL1,
        DP_BLK_MUL2,
        DP_BLK_MIX,
        DP_TAIL_MUL1,
        DP_TAIL_MUL2,
        DP_TAIL_MIX,
        DP_FIN0,
        DP_FIN1,
        DP_FIN2,
        DP_FIN3,
        DP_MOD_STEP,
        DP_BIT_READ,
        DP_BIT_CHECK
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic bcd_last;
        logic norm_done;
        logic more_blocks;
        logic has_tail;
        logic mod_last;
        logic last_hash;
        logic no_hashes;
        logic miss;
        logic is_query;
    } dp_status_t;

endpackage

// ===== hdl/bloom_filter_murmur3_decimal_key_unit.sv =====
// Top level of the Bloom filter key unit.
// Depends on bfm_pkg, bfm_ctrl, bfm_datapath (and bfm_ram below it).
`timescale 1ns / 1ps

// Usage:
//   Request channel: drive request and pulse start; a request is taken at a
//   clock edge where start is high and busy is low. Kinds: clear, insert, query.
//   Result channel: done is high for one cycle with result valid; the
//   receiver cannot stall it and must take it in that cycle.
//   Config: cfg_we with cfg_index/cfg_data, only while busy is low.
// Sequence, from the accepting edge to the result:
//   clear: a sweep of the bit array, one RAM word written per cycle.
//   insert/query: the 64-step binary-to-decimal loop, normalization,
//   then per hash the full 4-digit blocks (0..5), a tail when 1..3
//   digits are left over, the finalizer, the 32-step modulo unit and
//   the bit access (none with 0 hashes); a query stops after its first
//   clear bit. Unused kind: straight to the result.
// Throughput: one request at a time; busy falls the cycle after the result.
// Reset: the bit array is cleared by a full sweep with busy high and no
//   result; config registers return to 4 hashes, 65536 bits.
module bloom_filter_murmur3_decimal_key_unit #(
    parameter int ARRAY_BITS = 65536,
    parameter int MAX_HASHES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bfm_pkg::request_t request,
    output logic              done,
    output bfm_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [16:0]       cfg_data
);

    bfm_pkg::dp_cmd_t    cmd;
    bfm_pkg::dp_status_t status;

    bfm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_type (request.req_type),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done)
    );

    bfm_datapath #(
        .ARRAY_BITS (ARRAY_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

// ===== hdl/bfm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bfm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/bfm_datapath.sv =====
// Datapath: config registers, decimal conversion, hash unit, modulo unit, bit RAM.
// Depends on bfm_pkg and bfm_ram; driven by commands from bfm_ctrl.
`timescale 1ns / 1ps

module bfm_datapath #(
    parameter int ARRAY_BITS = 65536,
    parameter int MAX_HASHES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [16:0]         cfg_data,
    input  bfm_pkg::request_t   request,
    input  bfm_pkg::dp_cmd_t    cmd,
    output bfm_pkg::dp_status_t status,
    output bfm_pkg::result_t    result
);

    localparam int DEPTH = (ARRAY_BITS + bfm_pkg::WORD_BITS - 1) / bfm_pkg::WORD_BITS;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = $clog2(ARRAY_BITS + 1);
    localparam int CW    = (MW > 17) ? MW : 17;
    localparam int HW    = $clog2(MAX_HASHES + 1);
    localparam int EW    = (HW > 5) ? HW : 5;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    logic [4:0]    num_hashes_reg;
    logic [16:0]   num_bits_reg;
    logic [1:0]    kind_reg;
    logic [63:0]   key_reg;
    logic [79:0]   bcd_reg;
    logic [5:0]    bcd_cnt_reg;
    logic [4:0]    shift_cnt_reg;
    logic [31:0]   h_reg;
    logic [31:0]   t_reg;
    logic [2:0]    blk_reg;
    logic [31:0]   seed_reg;
    logic [EW-1:0] hash_cnt_reg;
    logic [CW-1:0] rem_reg;
    logic [31:0]   dvd_reg;
    logic [4:0]    mod_cnt_reg;
    logic          member_reg;
    logic [AW-1:0] clr_addr_reg;

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_hashes_reg <= bfm_pkg::NUM_HASHES_RESET;
            num_bits_reg   <= bfm_pkg::NUM_BITS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == bfm_pkg::CFG_NUM_HASHES)
            begin
                num_hashes_reg <= cfg_data[4:0];
            end
            else if (cfg_index == bfm_pkg::CFG_NUM_BITS)
            begin
                num_bits_reg <= cfg_data;
            end
        end
    end

    // effective modulus and hash count
    logic [CW-1:0] nb_ext;
    logic [CW-1:0] modulus;
    logic [EW-1:0] nh_ext;
    logic [EW-1:0] eff_hashes;
    assign nb_ext     = CW'(num_bits_reg);
    assign modulus    = (nb_ext == '0 || nb_ext > CW'(ARRAY_BITS)) ? CW'(ARRAY_BITS) : nb_ext;
    assign nh_ext     = EW'(num_hashes_reg);
    assign eff_hashes = (nh_ext > EW'(MAX_HASHES)) ? EW'(MAX_HASHES) : nh_ext;

    // key length from normalization shifts
    logic [4:0] key_len;
    logic [2:0] full_blocks;
    logic [1:0] tail_len;
    assign key_len     = 5'(bfm_pkg::NUM_DIGITS) - shift_cnt_reg;
    assign full_blocks = key_len[4:2];
    assign tail_len    = key_len[1:0];

    // double-dabble digit adjust
    logic [79:0] bcd_adj;
    always_comb
    begin
        for (int i = 0; i < bfm_pkg::NUM_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                             : bcd_reg[4*i +: 4];
        end
    end

    // ASCII word for the current block, digits most significant first
    logic [15:0] blk_digits;
    logic [31:0] blk_word;
    logic [31:0] tail_mask;
    always_comb
    begin
        unique case (blk_reg)
            3'd0:    blk_digits = bcd_reg[79:64];
            3'd1:    blk_digits = bcd_reg[63:48];
            3'd2:    blk_digits = bcd_reg[47:32];
            3'd3:    blk_digits = bcd_reg[31:16];
            3'd4:    blk_digits = bcd_reg[15:0];
            default: blk_digits = 16'h0000;
        endcase
        unique case (tail_len)
            2'd1:    tail_mask = 32'h000000ff;
            2'd2:    tail_mask = 32'h0000ffff;
            2'd3:    tail_mask = 32'h00ffffff;
            default: tail_mask = 32'h00000000;
        endcase
    end
    assign blk_word = {4'h3, blk_digits[3:0], 4'h3, blk_digits[7:4],
                       4'h3, blk_digits[11:8], 4'h3, blk_digits[15:12]};

    // finalizer helpers
    logic [31:0] fin0_x;
    logic [31:0] fin3_h;
    assign fin0_x = h_reg ^ {27'd0, key_len};
    assign fin3_h = h_reg ^ (h_reg >> 16);

    // restoring modulo trial
    logic [CW:0] mod_trial;
    logic        mod_fit;
    assign mod_trial = {rem_reg, dvd_reg[31]};
    assign mod_fit   = mod_trial >= {1'b0, modulus};

    // bit RAM
    logic [AW-1:0] word_addr;
    logic [31:0]   rd_data;
    logic          bit_set;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    assign word_addr = AW'(rem_reg >> 5);
    assign bit_set   = rd_data[rem_reg[4:0]];
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = word_addr;
        ram_wdata = rd_data | (32'd1 << rem_reg[4:0]);
        if (cmd.op == bfm_pkg::DP_CLR_STEP)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (cmd.op == bfm_pkg::DP_BIT_CHECK && kind_reg == bfm_pkg::REQ_INSERT)
        begin
            ram_we = 1'b1;
        end
    end

    bfm_ram #(
        .WIDTH (bfm_pkg::WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (word_addr),
        .rdata (rd_data)
    );

    // control-side counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            member_reg   <= 1'b0;
            kind_reg     <= bfm_pkg::REQ_CLEAR;
        end
        else
        begin
            unique case (cmd.op)
                bfm_pkg::DP_LOAD:
                begin
                    kind_reg   <= request.req_type;
                    member_reg <= 1'b1;
                end
                bfm_pkg::DP_CLR_STEP:
                begin
                    clr_addr_reg <= (clr_addr_reg == AW'(DEPTH - 1)) ? '0 : clr_addr_reg + 1'b1;
                end
                bfm_pkg::DP_BIT_CHECK:
                begin
                    if (!bit_set)
                    begin
                        member_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload datapath registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            bfm_pkg::DP_LOAD:
            begin
                key_reg       <= request.range_value;
                bcd_reg       <= '0;
                bcd_cnt_reg   <= '0;
                shift_cnt_reg <= '0;
                seed_reg      <= '0;
                hash_cnt_reg  <= '0;
            end
            bfm_pkg::DP_BCD_STEP:
            begin
                bcd_reg     <= {bcd_adj[78:0], key_reg[63]};
                key_reg     <= {key_reg[62:0], 1'b0};
                bcd_cnt_reg <= bcd_cnt_reg + 1'b1;
            end
            bfm_pkg::DP_NORM_STEP:
            begin
                if (!status.norm_done)
                begin
                    bcd_reg       <= {bcd_reg[75:0], 4'h0};
                    shift_cnt_reg <= shift_cnt_reg + 1'b1;
                end
            end
            bfm_pkg::DP_HASH_INIT:
            begin
                h_reg   <= seed_reg;
                blk_reg <= '0;
            end
            bfm_pkg::DP_BLK_MUL1:  t_reg <= 32'(blk_word * bfm_pkg::MUR_C1);
            bfm_pkg::DP_TAIL_MUL1: t_reg <= 32'((blk_word & tail_mask) * bfm_pkg::MUR_C1);
            bfm_pkg::DP_BLK_MUL2,
            bfm_pkg::DP_TAIL_MUL2: t_reg <= 32'(rotl(t_reg, 15) * bfm_pkg::MUR_C2);
            bfm_pkg::DP_BLK_MIX:
            begin
                h_reg   <= 32'(rotl(h_reg ^ t_reg, 13) * 32'd5) + bfm_pkg::MUR_ADD;
                blk_reg <= blk_reg + 1'b1;
            end
            bfm_pkg::DP_TAIL_MIX:  h_reg <= h_reg ^ t_reg;
            bfm_pkg::DP_FIN0:      h_reg <= fin0_x ^ (fin0_x >> 16);
            bfm_pkg::DP_FIN1:      h_reg <= 32'(h_reg * bfm_pkg::FMIX_C1);
            bfm_pkg::DP_FIN2:      h_reg <= 32'((h_reg ^ (h_reg >> 13)) * bfm_pkg::FMIX_C2);
            bfm_pkg::DP_FIN3:
            begin
                dvd_reg     <= fin3_h;
                rem_reg     <= '0;
                mod_cnt_reg <= '0;
            end
            bfm_pkg::DP_MOD_STEP:
            begin
                rem_reg     <= mod_fit ? CW'(mod_trial - {1'b0, modulus}) : CW'(mod_trial);
                dvd_reg     <= {dvd_reg[30:0], 1'b0};
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            end
            bfm_pkg::DP_BIT_CHECK:
            begin
                seed_reg     <= seed_reg + bfm_pkg::SEED_STEP;
                hash_cnt_reg <= hash_cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // status back to the controller
    assign status.clr_last    = clr_addr_reg == AW'(DEPTH - 1);
    assign status.bcd_last    = bcd_cnt_reg == 6'd63;
    assign status.norm_done   = (bcd_reg[79:76] != 4'h0) ||
                                (shift_cnt_reg == 5'(bfm_pkg::NUM_DIGITS - 1));
    assign status.more_blocks = blk_reg < full_blocks;
    assign status.has_tail    = tail_len != 2'd0;
    assign status.mod_last    = mod_cnt_reg == 5'd31;
    assign status.last_hash   = (hash_cnt_reg + 1'b1) >= eff_hashes;
    assign status.no_hashes   = eff_hashes == '0;
    assign status.miss        = !bit_set;
    assign status.is_query    = kind_reg == bfm_pkg::REQ_QUERY;

    assign result.is_member = (kind_reg == bfm_pkg::REQ_QUERY) && member_reg;
    assign result.done_type = kind_reg;

endmodule

// ===== hdl/bfm_ctrl.sv =====
// Controller state machine: sequences clear sweep, conversion, hashing and bit access.
// Depends on bfm_pkg; drives bfm_datapath through command and status structs.
`timescale 1ns / 1ps

module bfm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          start_type,
    input  bfm_pkg::dp_status_t status,
    output bfm_pkg::dp_cmd_t    cmd,
    output logic                busy,
    output logic                done
);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_BCD, ST_NORM, ST_HINIT, ST_HSEL,
        ST_M1, ST_M2, ST_M3, ST_T1, ST_T2, ST_T3,
        ST_F0, ST_F1, ST_F2, ST_F3, ST_MOD, ST_RD, ST_CHK, ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   from_req_reg, from_req_next;
    logic   busy_reg, done_reg;

    // next state and command decode
    always_comb
    begin
        state_next    = state_reg;
        from_req_next = from_req_reg;
        cmd.op        = bfm_pkg::DP_NOP;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = bfm_pkg::DP_CLR_STEP;
                if (status.clr_last)
                begin
                    state_next = from_req_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op = bfm_pkg::DP_LOAD;
                    priority if (start_type == bfm_pkg::REQ_CLEAR)
                    begin
                        state_next    = ST_CLEAR;
                        from_req_next = 1'b1;
                    end
                    else if (start_type == bfm_pkg::REQ_INSERT ||
                             start_type == bfm_pkg::REQ_QUERY)
                    begin
                        state_next = ST_BCD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_BCD:
            begin
                cmd.op = bfm_pkg::DP_BCD_STEP;
                if (status.bcd_last)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                cmd.op = bfm_pkg::DP_NORM_STEP;
                if (status.norm_done)
                begin
                    state_next = status.no_hashes ? ST_DONE : ST_HINIT;
                end
            end
            ST_HINIT:
            begin
                cmd.op     = bfm_pkg::DP_HASH_INIT;
                state_next = ST_HSEL;
            end
            ST_HSEL:
            begin
                priority if (status.more_blocks) state_next = ST_M1;
                else if (status.has_tail)         state_next = ST_T1;
                else                              state_next = ST_F0;
            end
            ST_M1: begin cmd.op = bfm_pkg::DP_BLK_MUL1;  state_next = ST_M2;   end
            ST_M2: begin cmd.op = bfm_pkg::DP_BLK_MUL2;  state_next = ST_M3;   end
            ST_M3: begin cmd.op = bfm_pkg::DP_BLK_MIX;   state_next = ST_HSEL; end
            ST_T1: begin cmd.op = bfm_pkg::DP_TAIL_MUL1; state_next = ST_T2;   end
            ST_T2: begin cmd.op = bfm_pkg::DP_TAIL_MUL2; state_next = ST_T3;   end
            ST_T3: begin cmd.op = bfm_pkg::DP_TAIL_MIX;  state_next = ST_F0;   end
            ST_F0: begin cmd.op = bfm_pkg::DP_FIN0;      state_next = ST_F1;   end
            ST_F1: begin cmd.op = bfm_pkg::DP_FIN1;      state_next = ST_F2;   end
            ST_F2: begin cmd.op = bfm_pkg::DP_FIN2;      state_next = ST_F3;   end
            ST_F3: begin cmd.op = bfm_pkg::DP_FIN3;      state_next = ST_MOD;  end
            ST_MOD:
            begin
                cmd.op = bfm_pkg::DP_MOD_STEP;
                if (status.mod_last)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin cmd.op = bfm_pkg::DP_BIT_READ;  state_next = ST_CHK;  end
            ST_CHK:
            begin
                cmd.op = bfm_pkg::DP_BIT_CHECK;
                // a query stops at the first clear bit
                if ((status.is_query && status.miss) || status.last_hash)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_HINIT;
                end
            end
            ST_DONE:
            begin
                state_next    = ST_IDLE;
                from_req_next = 1'b0;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            from_req_reg <= 1'b0;
            busy_reg     <= 1'b1;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            from_req_reg <= from_req_next;
            busy_reg     <= state_next != ST_IDLE;
            done_reg     <= state_next == ST_DONE;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy && state_reg == ST_DONE)
        else $error("result strobe outside the done state");
    a_idle_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !busy)
        else $error("busy while idle");
`endif

endmodule

// ===== dv/bloom_filter_murmur3_decimal_key_unit_test.sv =====
// Self-checking test of the Bloom filter key unit: directed and random requests
// against an in-bench filter predictor. Depends on bfm_pkg and the unit's RTL.
`timescale 1ns / 1ps

module bloom_filter_murmur3_decimal_key_unit_test;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // register indexes with no register behind them
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;
    localparam int FILTER_BITS = 65536;
    localparam int HASH_CAP = 16;
    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    bfm_pkg::request_t request = '0;
    logic done;
    bfm_pkg::result_t result;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [16:0] cfg_data = '0;

    bloom_filter_murmur3_decimal_key_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    bit [FILTER_BITS-1:0] filter_bits;
    logic [4:0] hash_count = bfm_pkg::NUM_HASHES_RESET;
    logic [16:0] bit_count = bfm_pkg::NUM_BITS_RESET;

    bfm_pkg::request_t pending_reqs[$];
    bfm_pkg::result_t expected_results[$];
    logic [63:0] key_pool[$];
    int errors = 0;
    int sent = 0;
    int stall_cycles = 0;
    bit taken = 1'b0;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // MurmurHash3 x86_32 over the decimal text of a key
    function automatic logic [31:0] key_hash(input logic [63:0] key, input logic [31:0] seed);
        logic [7:0] text[20];
        logic [7:0] rev[20];
        int len;
        int full;
        logic [31:0] h;
        logic [31:0] t;
        logic [63:0] v;
        len = 0;
        v = key;
        do
        begin
            rev[len] = 8'h30 + 8'(v % 10);
            v = v / 10;
            len++;
        end while (v != 0 && len < 20);
        for (int i = 0; i < len; i++) text[i] = rev[len - 1 - i];
        h = seed;
        full = len / 4;
        for (int b = 0; b < full; b++)
        begin
            t = {text[4*b+3], text[4*b+2], text[4*b+1], text[4*b]};
            t = rotl(t * bfm_pkg::MUR_C1, 15) * bfm_pkg::MUR_C2;
            h = rotl(h ^ t, 13) * 5 + bfm_pkg::MUR_ADD;
        end
        t = 0;
        if (len % 4 == 3) t ^= 32'(text[4*full+2]) << 16;
        if (len % 4 >= 2) t ^= 32'(text[4*full+1]) << 8;
        if (len % 4 >= 1)
        begin
            t ^= 32'(text[4*full]);
            t = rotl(t * bfm_pkg::MUR_C1, 15) * bfm_pkg::MUR_C2;
            h ^= t;
        end
        h ^= 32'(len);
        h ^= h >> 16;
        h *= bfm_pkg::FMIX_C1;
        h ^= h >> 13;
        h *= bfm_pkg::FMIX_C2;
        h ^= h >> 16;
        return h;
    endfunction

    // apply one request to the filter and return its answer
    function automatic bfm_pkg::result_t filter_apply(input bfm_pkg::request_t req);
        bfm_pkg::result_t res;
        int hashes;
        logic [31:0] modulus;
        logic [31:0] idx;
        bit member;
        res.is_member = 1'b0;
        res.done_type = req.req_type;
        hashes = (hash_count > HASH_CAP) ? HASH_CAP : int'(hash_count);
        modulus = (bit_count == 0 || bit_count > FILTER_BITS) ? FILTER_BITS : 32'(bit_count);
        member = 1'b1;
        if (req.req_type == bfm_pkg::REQ_CLEAR)
        begin
            filter_bits = '0;
        end
        else if (req.req_type != REQ_UNUSED)
        begin
            for (int j = 0; j < hashes; j++)
            begin
                idx = key_hash(req.range_value, bfm_pkg::SEED_STEP * 32'(j)) % modulus;
                if (req.req_type == bfm_pkg::REQ_INSERT) filter_bits[idx] = 1'b1;
                else if (!filter_bits[idx])
                begin
                    member = 1'b0;
                    break;
                end
            end
            if (req.req_type == bfm_pkg::REQ_QUERY) res.is_member = member;
        end
        return res;
    endfunction

    // accept requests, predict, and check results
    always @(posedge clk)
    begin
        bfm_pkg::result_t exp_res;
        taken = start && !busy && rst_n;
        if (taken) expected_results.push_back(filter_apply(request));
        if (done && rst_n)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: is_member %0d done_type %0d",
                       result.is_member, result.done_type);
                errors++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (result.is_member !== exp_res.is_member)
                begin
                    $error("is_member: expected %0d, got %0d", exp_res.is_member,
                           result.is_member);
                    errors++;
                end
                if (result.done_type !== exp_res.done_type)
                begin
                    $error("done_type: expected %0d, got %0d", exp_res.done_type,
                           result.done_type);
                    errors++;
                end
            end
        end
        // watchdog
        if (taken || done) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("bloom_filter_murmur3_decimal_key_unit test failed");
            $finish;
        end
    end

    // request driver: sender idles 21%, then 54%, then never
    always @(negedge clk)
    begin
        int idle_pct;
        idle_pct = (sent < 500) ? 21 : (sent < 1000) ? 54 : 0;
        if (!start || taken)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                request <= pending_reqs.pop_front();
                start <= 1'b1;
                sent++;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    task automatic push_req(input logic [1:0] kind, input logic [63:0] key);
        bfm_pkg::request_t r;
        r.req_type = kind;
        r.range_value = key;
        pending_reqs.push_back(r);
        if (kind == bfm_pkg::REQ_INSERT) key_pool.push_back(key);
    endtask

    // hold off until every request is done and the unit is idle
    task automatic drain();
        while (pending_reqs.size() != 0 || start || expected_results.size() != 0 || busy)
            @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [16:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == bfm_pkg::CFG_NUM_HASHES) hash_count = data[4:0];
        else if (idx == bfm_pkg::CFG_NUM_BITS) bit_count = data;
    endtask

    function automatic logic [63:0] pick_key();
        unique case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 99999));
            2: return (key_pool.size() != 0) ? key_pool[$urandom_range(key_pool.size() - 1)]
                                             : 64'($urandom);
            default: return {32'($urandom_range(0, 3)), $urandom} >> $urandom_range(0, 40);
        endcase
    endfunction

    task automatic random_batch(input int count);
        int roll;
        logic [63:0] key;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            key = pick_key();
            if (roll < 2) push_req(bfm_pkg::REQ_CLEAR, key);
            else if (roll < 5) push_req(REQ_UNUSED, key);
            else if (roll < 50) push_req(bfm_pkg::REQ_INSERT, key);
            else push_req(bfm_pkg::REQ_QUERY, key);
        end
    endtask

    // configuration settings per phase: hashes, modulus, request count
    int phase_hashes[8] = '{1, 16, 0, 31, 2, 3, 5, 4};
    int phase_bits[8] = '{8, 65536, 100, 0, 131071, 1000, 300, 65536};
    int phase_items[8] = '{150, 60, 100, 40, 250, 350, 300, 230};

    initial
    begin
        filter_bits = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty filter, extreme keys, digit-block boundaries, unused kind, clear
        push_req(bfm_pkg::REQ_QUERY, 64'd0);
        push_req(bfm_pkg::REQ_INSERT, 64'd0);
        push_req(bfm_pkg::REQ_QUERY, 64'd0);
        push_req(bfm_pkg::REQ_QUERY, '1);
        push_req(bfm_pkg::REQ_INSERT, '1);
        push_req(bfm_pkg::REQ_QUERY, '1);
        push_req(bfm_pkg::REQ_INSERT, 64'd9999);
        push_req(bfm_pkg::REQ_QUERY, 64'd9999);
        push_req(bfm_pkg::REQ_QUERY, 64'd12345);
        push_req(bfm_pkg::REQ_INSERT, 64'd12345678);
        push_req(bfm_pkg::REQ_QUERY, 64'd12345678);
        push_req(REQ_UNUSED, 64'hA5A5_5A5A_0F0F_F0F0);
        push_req(bfm_pkg::REQ_QUERY, 64'h5A5A_A5A5_F0F0_0F0F);
        push_req(bfm_pkg::REQ_CLEAR, 64'd7);
        push_req(bfm_pkg::REQ_QUERY, '1);
        push_req(bfm_pkg::REQ_QUERY, 64'd9999);
        drain();

        // write the ignored register indexes; each phase below then sets both registers
        reg_write(CFG_SPARE_A, 17'h1FFFF);
        reg_write(CFG_SPARE_B, 17'h00000);

        for (int p = 0; p < 8; p++)
        begin
            reg_write(bfm_pkg::CFG_NUM_HASHES, 17'(phase_hashes[p]));
            reg_write(bfm_pkg::CFG_NUM_BITS, 17'(phase_bits[p]));
            random_batch(phase_items[p]);
            drain();
        end

        repeat (50) @(negedge clk);
        if (errors == 0) $display("bloom_filter_murmur3_decimal_key_unit test passed");
        else $display("bloom_filter_murmur3_decimal_key_unit test failed");
        $finish;
    end

endmodule
